[hw/rtl/srpg_pkg.sv]
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared widths, register indexes, constants and controller/datapath
// command and status types for the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

	// Field and register widths
	localparam int unsigned STEPS_W = 16;
	localparam int unsigned SPEED_W = 16;
	localparam int unsigned RAMP_W  = 7;
	localparam int unsigned NUM_W   = 16;
	localparam int unsigned PHASE_W = 8;
	localparam int unsigned ACC_W   = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CIDX_W  = 2;

	// Shared divider operand widths
	localparam int unsigned DVD_W = 23;  // step index times 100 fits here
	localparam int unsigned DVS_W = 30;  // speed bits 30:1

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_RAMP  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_NUM   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_PHASE = 2'd2;

	// Reset values of the configuration registers
	localparam logic [RAMP_W-1:0]  RAMP_RST  = 7'd5;
	localparam logic [NUM_W-1:0]   NUM_RST   = 16'd10000;
	localparam logic [PHASE_W-1:0] PHASE_RST = 8'd50;

	localparam logic [RAMP_W:0] PCT_FULL = 8'd100;

	// Input command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Which quotient the shared divider is producing
	typedef enum logic [1:0] {
		DIV_INC,
		DIV_PCT,
		DIV_PER
	} srpg_div_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic          clr_flags;
		logic          latch_start;
		logic          reject;
		logic          tick;
		logic          div_go;
		srpg_div_sel_t div_sel;
		logic          wr_inc;
		logic          zero_move;
		logic          step_next;
		logic          wr_speed;
		logic          set_per_num;
		logic          set_per_div;
		logic          load_out;
	} srpg_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic moving;
		logic tick_begin;
		logic steps_zero;
		logic spd_ok;
		logic div_done;
	} srpg_sts_t;

endpackage

[hw/rtl/srpg_div.sv]
// ----------------------------------------------------------------------------
// srpg_div
// Restoring unsigned divider, one quotient bit per cycle. Operands are
// captured on go; done pulses for one cycle once the quotient is ready.
// ----------------------------------------------------------------------------
module srpg_div import srpg_pkg::*; #(
	parameter int unsigned DW = DVD_W,
	parameter int unsigned SW = DVS_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] dividend,
	input  logic [SW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);

	localparam int unsigned CNT_W = (DW > 1) ? $clog2(DW) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

	logic [DW-1:0]    dvd_q;
	logic [SW-1:0]    dvs_q;
	logic [SW:0]      rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SW:0]      trial;
	logic             fits;

	// Shift in the next dividend bit and test against the divisor
	assign trial = {rem_q[SW-1:0], dvd_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			dvd_q <= {dvd_q[DW-2:0], fits};
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

[hw/rtl/srpg_datapath.sv]
// ----------------------------------------------------------------------------
// srpg_datapath
// Configuration registers, move state, tick counting, speed ramp and the
// result register. Divisions go through the shared srpg_div unit.
// ----------------------------------------------------------------------------
module srpg_datapath import srpg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic [STEPS_W-1:0] move_steps,
	input  logic [SPEED_W-1:0] target_speed,
	input  srpg_cmd_t          cmd_c,
	output srpg_sts_t          sts,
	output logic               step_level,
	output logic               busy_res,
	output logic               step_done,
	output logic               move_done,
	output logic               rejected
);

	logic [RAMP_W-1:0]  ramp_q;
	logic [NUM_W-1:0]   num_q;
	logic [PHASE_W-1:0] phase_cfg_q;

	logic               moving_q;
	logic [STEPS_W-1:0] total_q;
	logic [STEPS_W-1:0] idx_q;
	logic [SPEED_W-1:0] inc_q;
	logic [ACC_W-1:0]   speed_q;
	logic [NUM_W-1:0]   per_len_q;
	logic [NUM_W-1:0]   per_ticks_q;
	logic [PHASE_W-1:0] phase_q;
	logic               pulse_q;
	logic               sdone_q;
	logic               mdone_q;
	logic               rej_q;

	logic               out_level_q;
	logic               out_busy_q;
	logic               out_sdone_q;
	logic               out_mdone_q;
	logic               out_rej_q;

	logic [DVD_W-1:0]   div_dvd;
	logic [DVS_W-1:0]   div_dvs;
	logic [DVD_W-1:0]   div_q;
	logic               div_done;

	logic [RAMP_W-1:0]  ramp_div;
	logic [PHASE_W-1:0] phase_cnt;
	logic [DVD_W-1:0]   idx_x100;
	logic [RAMP_W-1:0]  pct;
	logic [RAMP_W:0]    pct_sum;
	logic [NUM_W-1:0]   per_src;
	logic [NUM_W-1:0]   per_fix;

	// Repaired divisors and counts
	assign ramp_div  = (ramp_q == '0) ? RAMP_W'(1) : ramp_q;
	assign phase_cnt = (phase_cfg_q == '0) ? PHASE_W'(1) : phase_cfg_q;

	// step index times 100 as shift-and-add (64 + 32 + 4)
	assign idx_x100 = (DVD_W'(idx_q) << 6) + (DVD_W'(idx_q) << 5) + (DVD_W'(idx_q) << 2);

	// Divider operand select
	always_comb begin
		unique case (cmd_c.div_sel)
			DIV_INC: begin
				div_dvd = DVD_W'(target_speed);
				div_dvs = DVS_W'(ramp_div);
			end
			DIV_PCT: begin
				div_dvd = idx_x100;
				div_dvs = DVS_W'(total_q);
			end
			DIV_PER: begin
				div_dvd = DVD_W'(num_q);
				div_dvs = speed_q[DVS_W:1];
			end
			default: begin
				div_dvd = '0;
				div_dvs = '0;
			end
		endcase
	end

	srpg_div #(
		.DW(DVD_W),
		.SW(DVS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cmd_c.div_go),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.quotient(div_q),
		.done    (div_done)
	);

	// Percent never exceeds 100, so seven bits hold it
	assign pct     = div_q[RAMP_W-1:0];
	assign pct_sum = {1'b0, pct} + {1'b0, ramp_q};

	// Period length, never below one tick
	assign per_src = cmd_c.set_per_div ? div_q[NUM_W-1:0] : num_q;
	assign per_fix = (per_src == '0) ? NUM_W'(1) : per_src;

	// Status to the controller
	assign sts.moving     = moving_q;
	assign sts.tick_begin = moving_q && (per_ticks_q <= NUM_W'(1))
		&& (phase_q <= PHASE_W'(1)) && !pulse_q && (idx_q < total_q);
	assign sts.steps_zero = (total_q == '0);
	assign sts.spd_ok     = !speed_q[ACC_W-1] && (speed_q[ACC_W-2:1] != '0);
	assign sts.div_done   = div_done;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q      <= RAMP_RST;
			num_q       <= NUM_RST;
			phase_cfg_q <= PHASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RAMP:  ramp_q      <= cfg_data[RAMP_W-1:0];
				REG_NUM:   num_q       <= cfg_data[NUM_W-1:0];
				REG_PHASE: phase_cfg_q <= cfg_data[PHASE_W-1:0];
				default:   ;
			endcase
		end
	end

	// Move state and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q    <= 1'b0;
			total_q     <= '0;
			idx_q       <= '0;
			inc_q       <= '0;
			speed_q     <= '0;
			per_len_q   <= '0;
			per_ticks_q <= '0;
			phase_q     <= '0;
			pulse_q     <= 1'b0;
			sdone_q     <= 1'b0;
			mdone_q     <= 1'b0;
			rej_q       <= 1'b0;
		end else begin
			if (cmd_c.clr_flags) begin
				sdone_q <= 1'b0;
				mdone_q <= 1'b0;
				rej_q   <= 1'b0;
			end
			if (cmd_c.reject) begin
				rej_q <= 1'b1;
			end
			if (cmd_c.latch_start) begin
				total_q <= move_steps;
				speed_q <= '0;
				idx_q   <= '0;
			end
			if (cmd_c.wr_inc) begin
				inc_q <= div_q[SPEED_W-1:0];
			end
			if (cmd_c.zero_move) begin
				mdone_q     <= 1'b1;
				pulse_q     <= 1'b0;
				phase_q     <= '0;
				per_ticks_q <= '0;
			end
			// One microsecond tick
			if (cmd_c.tick && moving_q) begin
				if (per_ticks_q > NUM_W'(1)) begin
					per_ticks_q <= per_ticks_q - NUM_W'(1);
				end else begin
					per_ticks_q <= per_len_q;
					if (phase_q > PHASE_W'(1)) begin
						phase_q <= phase_q - PHASE_W'(1);
					end else if (pulse_q) begin
						pulse_q <= 1'b0;
						phase_q <= phase_cnt;
					end else begin
						sdone_q <= 1'b1;
						if (idx_q >= total_q) begin
							moving_q    <= 1'b0;
							mdone_q     <= 1'b1;
							phase_q     <= '0;
							per_ticks_q <= '0;
						end
					end
				end
			end
			// Step begin: advance index, ramp speed, then load period
			if (cmd_c.step_next) begin
				moving_q <= 1'b1;
				idx_q    <= idx_q + STEPS_W'(1);
			end
			if (cmd_c.wr_speed) begin
				if ({1'b0, pct} <= {1'b0, ramp_q}) begin
					speed_q <= speed_q + ACC_W'(inc_q);
				end else if (pct_sum >= PCT_FULL) begin
					speed_q <= speed_q - ACC_W'(inc_q);
				end
			end
			if (cmd_c.set_per_num || cmd_c.set_per_div) begin
				per_len_q   <= per_fix;
				per_ticks_q <= per_fix;
				phase_q     <= phase_cnt;
				pulse_q     <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_level_q <= 1'b0;
			out_busy_q  <= 1'b0;
			out_sdone_q <= 1'b0;
			out_mdone_q <= 1'b0;
			out_rej_q   <= 1'b0;
		end else if (cmd_c.load_out) begin
			out_level_q <= pulse_q;
			out_busy_q  <= moving_q;
			out_sdone_q <= sdone_q;
			out_mdone_q <= mdone_q;
			out_rej_q   <= rej_q;
		end
	end

	assign step_level = out_level_q;
	assign busy_res   = out_busy_q;
	assign step_done  = out_sdone_q;
	assign move_done  = out_mdone_q;
	assign rejected   = out_rej_q;

endmodule

[hw/rtl/srpg_ctrl.sv]
// ----------------------------------------------------------------------------
// srpg_ctrl
// Sequencer for one item at a time: start setup, tick update, step begin
// (percent and period divisions) and the result handoff.
// ----------------------------------------------------------------------------
module srpg_ctrl import srpg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      cmd,
	output logic      out_valid,
	input  logic      out_ready,
	input  srpg_sts_t sts,
	output srpg_cmd_t cmd_c
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INC_RUN,
		S_STEP_INC,
		S_PCT_GO,
		S_PCT_RUN,
		S_PER_GO,
		S_PER_RUN,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   in_xfer;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd_c   = '0;
		cmd_c.div_sel = DIV_INC;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					cmd_c.clr_flags = 1'b1;
					if (cmd == CMD_START) begin
						if (sts.moving) begin
							cmd_c.reject = 1'b1;
							state_d = S_FIN;
						end else begin
							cmd_c.latch_start = 1'b1;
							cmd_c.div_go      = 1'b1;
							cmd_c.div_sel     = DIV_INC;
							state_d = S_INC_RUN;
						end
					end else begin
						cmd_c.tick = 1'b1;
						state_d = sts.tick_begin ? S_STEP_INC : S_FIN;
					end
				end
			end
			S_INC_RUN: begin
				if (sts.div_done) begin
					cmd_c.wr_inc = 1'b1;
					if (sts.steps_zero) begin
						cmd_c.zero_move = 1'b1;
						state_d = S_FIN;
					end else begin
						state_d = S_STEP_INC;
					end
				end
			end
			S_STEP_INC: begin
				cmd_c.step_next = 1'b1;
				state_d = S_PCT_GO;
			end
			S_PCT_GO: begin
				cmd_c.div_go  = 1'b1;
				cmd_c.div_sel = DIV_PCT;
				state_d = S_PCT_RUN;
			end
			S_PCT_RUN: begin
				cmd_c.div_sel = DIV_PCT;
				if (sts.div_done) begin
					cmd_c.wr_speed = 1'b1;
					state_d = S_PER_GO;
				end
			end
			S_PER_GO: begin
				if (sts.spd_ok) begin
					cmd_c.div_go  = 1'b1;
					cmd_c.div_sel = DIV_PER;
					state_d = S_PER_RUN;
				end else begin
					cmd_c.set_per_num = 1'b1;
					state_d = S_FIN;
				end
			end
			S_PER_RUN: begin
				cmd_c.div_sel = DIV_PER;
				if (sts.div_done) begin
					cmd_c.set_per_div = 1'b1;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd_c.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_c.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/stepper_ramp_pulse_generator.sv]
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Step pulse generator with a trapezoidal speed ramp: start items set up a
// move, microsecond tick items drive the step pin level.
//
//   channel  signals                                   direction
//   in       in_valid/in_ready cmd move_steps          input
//            target_speed
//   out      out_valid/out_ready step_level busy_res   output
//            step_done move_done rejected
//   cfg      cfg_we cfg_index cfg_data                 input, write only
//
// A tick that does not begin a step and a refused start need no division;
// a zero-step start needs one. Each division runs in the shared radix-2
// divider at one quotient bit per cycle: two per step begin (one when the
// speed is too low to divide), one more for the start's increment. Reset
// clears all move state; config returns to defaults. One item is in flight
// at a time; a new item is taken while the previous result waits in the
// output register, and a stalled output holds the next result until the
// previous one transfers.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator import srpg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [STEPS_W-1:0] move_steps,
	input  logic [SPEED_W-1:0] target_speed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               step_level,
	output logic               busy_res,
	output logic               step_done,
	output logic               move_done,
	output logic               rejected
);

	srpg_cmd_t cmd_c;
	srpg_sts_t sts;

	// Sequencer
	srpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd_c    (cmd_c)
	);

	// State, arithmetic and result register
	srpg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.move_steps  (move_steps),
		.target_speed(target_speed),
		.cmd_c       (cmd_c),
		.sts         (sts),
		.step_level  (step_level),
		.busy_res    (busy_res),
		.step_done   (step_done),
		.move_done   (move_done),
		.rejected    (rejected)
	);

endmodule
